/* hdl/dchc_pkg.sv */
package dchc_pkg;

  localparam int CH_W = 12;
  localparam int ADC_W = 16;
  localparam int STAMP_W = 64;
  localparam int DET_W = 4;
  localparam int STRIP_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int TBL_W = 10;
  localparam int OFF_W = 7;

  localparam logic [31:0] END_MARK = 32'hffff_ffff;

  localparam logic [CH_W-1:0] CH_TDC_GAMMA = 12'd839;
  localparam logic [CH_W-1:0] CH_TDC_RF = 12'd836;
  localparam logic [CH_W-1:0] CH_TDC_SILICON = 12'd835;
  localparam logic [CH_W-1:0] CH_STAMP_LO = 12'd1000;
  localparam logic [CH_W-1:0] CH_STAMP_HI = 12'd1003;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    KIND_RING   = 3'd0,
    KIND_SECTOR = 3'd1,
    KIND_BACK   = 3'd2,
    KIND_FRONT  = 3'd3,
    KIND_TELE   = 3'd4,
    KIND_END    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    THR_RS  = 2'd0,
    THR_BAR = 2'd1,
    THR_TEL = 2'd2
  } thr_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_SECTOR = 2'd0,
    CFG_BARREL      = 2'd1,
    CFG_TELESCOPE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TBL_W-1:0] lo;
    logic [TBL_W-1:0] hi;
    kind_t            kind;
    logic             ds;
    thr_sel_t         thr;
    logic [2:0]       shift;
    logic [DET_W-1:0] base;
    logic             dual;
  } range_t;

  localparam int NUM_RANGES = 22;
  localparam int RANGE_IW = $clog2(NUM_RANGES);

  localparam range_t RANGES [NUM_RANGES] = '{
    '{10'd1,   10'd128, KIND_RING,   1'b0, THR_RS,  3'd5, 4'd0,  1'b0},
    '{10'd129, 10'd144, KIND_SECTOR, 1'b0, THR_RS,  3'd2, 4'd0,  1'b0},
    '{10'd145, 10'd160, KIND_BACK,   1'b0, THR_BAR, 3'd2, 4'd0,  1'b0},
    '{10'd161, 10'd176, KIND_BACK,   1'b0, THR_BAR, 3'd2, 4'd6,  1'b0},
    '{10'd177, 10'd184, KIND_BACK,   1'b0, THR_BAR, 3'd2, 4'd4,  1'b0},
    '{10'd185, 10'd192, KIND_BACK,   1'b0, THR_BAR, 3'd2, 4'd10, 1'b0},
    '{10'd193, 10'd288, KIND_FRONT,  1'b0, THR_BAR, 3'd3, 4'd0,  1'b0},
    '{10'd289, 10'd384, KIND_FRONT,  1'b1, THR_BAR, 3'd3, 4'd0,  1'b0},
    '{10'd385, 10'd400, KIND_BACK,   1'b1, THR_BAR, 3'd2, 4'd0,  1'b0},
    '{10'd401, 10'd416, KIND_BACK,   1'b1, THR_BAR, 3'd2, 4'd6,  1'b0},
    '{10'd417, 10'd424, KIND_BACK,   1'b1, THR_BAR, 3'd2, 4'd4,  1'b0},
    '{10'd425, 10'd432, KIND_BACK,   1'b1, THR_BAR, 3'd2, 4'd10, 1'b0},
    '{10'd433, 10'd496, KIND_TELE,   1'b1, THR_TEL, 3'd3, 4'd0,  1'b0},
    '{10'd497, 10'd560, KIND_RING,   1'b1, THR_RS,  3'd5, 4'd0,  1'b0},
    '{10'd561, 10'd564, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd0,  1'b0},
    '{10'd569, 10'd572, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd1,  1'b0},
    '{10'd577, 10'd640, KIND_RING,   1'b1, THR_RS,  3'd5, 4'd2,  1'b0},
    '{10'd641, 10'd672, KIND_RING,   1'b1, THR_RS,  3'd5, 4'd5,  1'b0},
    '{10'd673, 10'd676, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd2,  1'b0},
    '{10'd677, 10'd680, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd4,  1'b1},
    '{10'd681, 10'd684, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd3,  1'b0},
    '{10'd685, 10'd688, KIND_SECTOR, 1'b1, THR_RS,  3'd2, 4'd5,  1'b0}
  };

  // One queue entry: a hit (dual marks a sector hit followed by a ring hit)
  // or an event record.
  typedef struct packed {
    kind_t              kind;
    logic               ds;
    logic [DET_W-1:0]   det;
    logic [STRIP_W-1:0] strip;
    logic               left;
    logic [CH_W-1:0]    ch;
    logic [ADC_W-1:0]   adc;
    logic               dual;
    logic [STAMP_W-1:0] stamp;
    logic [ADC_W-1:0]   tdc_gamma;
    logic [ADC_W-1:0]   tdc_rf;
    logic [ADC_W-1:0]   tdc_silicon;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hdl/detector_channel_hit_classifier_top.sv */
// Channel  Handshake            Payload
// in       in_valid/in_ready    raw_word
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
// out      out_valid/out_ready  kind .. tdc_silicon, last
//
// One readout word is taken per cycle while in_ready is high; the front classifies it
// in the cycle it is taken and queues at most one entry into a four-deep queue. A
// result passes the queue memory, then the output register; a shared sector/ring
// channel word leaves as two beats, so the output port sets the sustained rate at
// one beat per cycle while out_ready is high. Reset clears thresholds, latches,
// queue. in_ready drops only while the queue is full; cfg_ready is always high.
module detector_channel_hit_classifier_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      raw_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dchc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dchc_pkg::ADC_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       kind,
  output logic                             downstream,
  output logic [dchc_pkg::DET_W-1:0]       detector,
  output logic [dchc_pkg::STRIP_W-1:0]     strip,
  output logic                             left_side,
  output logic [dchc_pkg::CH_W-1:0]        channel,
  output logic [dchc_pkg::ADC_W-1:0]       adc,
  output logic [dchc_pkg::STAMP_W-1:0]     time_stamp,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_gamma,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_rf,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_silicon,
  output logic                             last
);
  import dchc_pkg::*;

  logic       push;
  logic       pop;
  entry_t     push_entry;
  entry_t     head;
  fifo_stat_t fifo_stat;

  dchc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_word   (raw_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  dchc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  dchc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fifo_stat   (fifo_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .downstream  (downstream),
    .detector    (detector),
    .strip       (strip),
    .left_side   (left_side),
    .channel     (channel),
    .adc         (adc),
    .time_stamp  (time_stamp),
    .tdc_gamma   (tdc_gamma),
    .tdc_rf      (tdc_rf),
    .tdc_silicon (tdc_silicon),
    .last        (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_stat.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_stat.empty)
    else $error("queue read while empty");

  a_split_is_sector: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (kind == KIND_SECTOR))
    else $error("non-final beat is not a sector hit");

  a_split_then_ring: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && last && kind == KIND_RING))
    else $error("sector beat not followed by its ring beat");

endmodule

/* hdl/dchc_front.sv */
module dchc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      raw_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dchc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dchc_pkg::ADC_W-1:0]       cfg_data,
  input  dchc_pkg::fifo_stat_t             fifo_stat,
  output logic                             push,
  output dchc_pkg::entry_t                 push_entry
);
  import dchc_pkg::*;

  logic [ADC_W-1:0]   thr_rs;
  logic [ADC_W-1:0]   thr_bar;
  logic [ADC_W-1:0]   thr_tel;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] stamp_next;
  logic [ADC_W-1:0]   tdc_gamma;
  logic [ADC_W-1:0]   tdc_rf;
  logic [ADC_W-1:0]   tdc_silicon;

  logic               accept;
  logic               is_end;
  logic [CH_W-1:0]    ch;
  logic [ADC_W-1:0]   adc;
  logic               hit_any;
  logic [RANGE_IW-1:0] hit_idx;
  range_t             rng;
  logic [ADC_W-1:0]   thr;
  logic [CH_W-1:0]    off_full;
  logic [OFF_W-1:0]   off;
  logic [OFF_W-1:0]   strip_mask;
  logic [OFF_W-1:0]   det_raw;
  logic [STRIP_W-1:0] strip_raw;
  logic               above;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_stat.full;
  assign accept    = in_valid && in_ready;

  // Halves swap: channel sits in the low half of the raw word, ADC in the high.
  assign is_end = (raw_word == END_MARK);
  assign ch     = raw_word[CH_W-1:0];
  assign adc    = raw_word[31:16];

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (ch >= {2'b00, RANGES[i].lo} && ch <= {2'b00, RANGES[i].hi}) begin
        hit_any = 1'b1;
        hit_idx = RANGE_IW'(i);
      end
    end
  end

  always_comb begin
    rng = RANGES[hit_idx];
    unique case (rng.thr)
      THR_RS:  thr = thr_rs;
      THR_BAR: thr = thr_bar;
      THR_TEL: thr = thr_tel;
      default: thr = thr_rs;
    endcase
    above      = adc > thr;
    off_full   = ch - {2'b00, rng.lo};
    off        = off_full[OFF_W-1:0];
    strip_mask = OFF_W'((8'd1 << rng.shift) - 8'd1);
    det_raw    = (off >> rng.shift) + {3'b000, rng.base};
    strip_raw  = STRIP_W'(off & strip_mask);
  end

  always_comb begin
    push_entry             = '0;
    push_entry.kind        = rng.kind;
    push_entry.ds          = rng.ds;
    push_entry.det         = det_raw[DET_W-1:0];
    push_entry.strip       = strip_raw;
    push_entry.ch          = ch;
    push_entry.adc         = adc;
    push_entry.dual        = rng.dual;
    if (rng.kind == KIND_FRONT) begin
      push_entry.strip = strip_raw >> 1;
      push_entry.left  = !ch[0];
    end
    if (is_end) begin
      push_entry             = '0;
      push_entry.kind        = KIND_END;
      push_entry.stamp       = stamp;
      push_entry.tdc_gamma   = tdc_gamma;
      push_entry.tdc_rf      = tdc_rf;
      push_entry.tdc_silicon = tdc_silicon;
    end
    push = accept && (is_end || (hit_any && above));
  end

  always_comb begin
    stamp_next = stamp;
    if (ch >= CH_STAMP_LO && ch <= CH_STAMP_HI) begin
      stamp_next = stamp | ({{(STAMP_W-ADC_W){1'b0}}, adc} << {ch[1:0], 4'b0000});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_rs  <= '0;
      thr_bar <= '0;
      thr_tel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RING_SECTOR: thr_rs  <= cfg_data;
        CFG_BARREL:      thr_bar <= cfg_data;
        CFG_TELESCOPE:   thr_tel <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp       <= '0;
      tdc_gamma   <= '0;
      tdc_rf      <= '0;
      tdc_silicon <= '0;
    end else if (accept) begin
      if (is_end) begin
        // Drop all latches once the event record is queued.
        stamp       <= '0;
        tdc_gamma   <= '0;
        tdc_rf      <= '0;
        tdc_silicon <= '0;
      end else begin
        stamp <= stamp_next;
        if (ch == CH_TDC_GAMMA)   tdc_gamma   <= adc;
        if (ch == CH_TDC_RF)      tdc_rf      <= adc;
        if (ch == CH_TDC_SILICON) tdc_silicon <= adc;
      end
    end
  end

endmodule

/* hdl/dchc_fifo.sv */
module dchc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dchc_pkg::entry_t     push_entry,
  input  logic                 pop,
  output dchc_pkg::entry_t     head,
  output dchc_pkg::fifo_stat_t stat
);
  import dchc_pkg::*;

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/dchc_back.sv */
module dchc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  dchc_pkg::entry_t                 head,
  input  dchc_pkg::fifo_stat_t             fifo_stat,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       kind,
  output logic                             downstream,
  output logic [dchc_pkg::DET_W-1:0]       detector,
  output logic [dchc_pkg::STRIP_W-1:0]     strip,
  output logic                             left_side,
  output logic [dchc_pkg::CH_W-1:0]        channel,
  output logic [dchc_pkg::ADC_W-1:0]       adc,
  output logic [dchc_pkg::STAMP_W-1:0]     time_stamp,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_gamma,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_rf,
  output logic [dchc_pkg::ADC_W-1:0]       tdc_silicon,
  output logic                             last
);
  import dchc_pkg::*;

  logic load;
  logic second;
  logic split;

  assign load  = !fifo_stat.empty && (!out_valid || out_ready);
  // A shared channel entry leaves as two beats: sector first, then ring.
  assign split = head.dual && !second;
  assign pop   = load && !split;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= split;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= second ? KIND_RING : head.kind;
      downstream  <= head.ds;
      detector    <= head.det;
      strip       <= head.strip;
      left_side   <= head.left;
      channel     <= head.ch;
      adc         <= head.adc;
      time_stamp  <= head.stamp;
      tdc_gamma   <= head.tdc_gamma;
      tdc_rf      <= head.tdc_rf;
      tdc_silicon <= head.tdc_silicon;
      last        <= !split;
    end
  end

endmodule

/* tb/tb_detector_channel_hit_classifier_top.sv */
`timescale 1ns / 100ps

module tb_detector_channel_hit_classifier_top;
  import dchc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 80;

  typedef struct {
    bit          hit;
    logic [11:0] lo;
    kind_t       kind;
    bit          ds;
    thr_sel_t    thr;
    int unsigned div;
    logic [3:0]  base;
    bit          dual;
  } chan_map_t;

  typedef struct {
    kind_t       kind;
    logic        ds;
    logic [3:0]  det;
    logic [4:0]  strip;
    logic        left;
    logic [11:0] ch;
    logic [15:0] adc;
    logic [63:0] stamp;
    logic [15:0] tdc_g;
    logic [15:0] tdc_r;
    logic [15:0] tdc_s;
    logic        last;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] raw_word = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADC_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] kind;
  logic downstream;
  logic [DET_W-1:0] detector;
  logic [STRIP_W-1:0] strip;
  logic left_side;
  logic [CH_W-1:0] channel;
  logic [ADC_W-1:0] adc;
  logic [STAMP_W-1:0] time_stamp;
  logic [ADC_W-1:0] tdc_gamma;
  logic [ADC_W-1:0] tdc_rf;
  logic [ADC_W-1:0] tdc_silicon;
  logic last;

  // predictor copy of thresholds and latches
  logic [15:0] rs_limit = '0;
  logic [15:0] barrel_limit = '0;
  logic [15:0] tele_limit = '0;
  logic [63:0] stamp_bits = '0;
  logic [15:0] gamma_seen = '0;
  logic [15:0] rf_seen = '0;
  logic [15:0] silicon_seen = '0;

  logic [31:0] word_backlog[$];
  hit_rec_t expected_hits[$];
  hit_rec_t exp_hit;
  int words_queued = 0;
  int words_accepted = 0;
  int beats_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit fast_in = 1'b0;
  bit fast_out = 1'b0;
  logic next_valid;

  detector_channel_hit_classifier_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .raw_word(raw_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .downstream(downstream), .detector(detector), .strip(strip),
    .left_side(left_side), .channel(channel), .adc(adc),
    .time_stamp(time_stamp), .tdc_gamma(tdc_gamma), .tdc_rf(tdc_rf),
    .tdc_silicon(tdc_silicon), .last(last)
  );

  always #1 clk = ~clk;

  function automatic chan_map_t span(input logic [11:0] lo, input kind_t k, input bit ds,
                                     input thr_sel_t thr, input int unsigned div,
                                     input logic [3:0] base, input bit dual);
    chan_map_t m;
    m.hit = 1'b1;
    m.lo = lo;
    m.kind = k;
    m.ds = ds;
    m.thr = thr;
    m.div = div;
    m.base = base;
    m.dual = dual;
    return m;
  endfunction

  function automatic chan_map_t map_channel(input logic [11:0] ch);
    chan_map_t m;
    m = span(12'd0, KIND_RING, 1'b0, THR_RS, 1, 4'd0, 1'b0);
    m.hit = 1'b0;
    if (ch >= 1 && ch <= 128) m = span(1, KIND_RING, 0, THR_RS, 32, 0, 0);
    else if (ch >= 129 && ch <= 144) m = span(129, KIND_SECTOR, 0, THR_RS, 4, 0, 0);
    else if (ch >= 145 && ch <= 160) m = span(145, KIND_BACK, 0, THR_BAR, 4, 0, 0);
    else if (ch >= 161 && ch <= 176) m = span(161, KIND_BACK, 0, THR_BAR, 4, 6, 0);
    else if (ch >= 177 && ch <= 184) m = span(177, KIND_BACK, 0, THR_BAR, 4, 4, 0);
    else if (ch >= 185 && ch <= 192) m = span(185, KIND_BACK, 0, THR_BAR, 4, 10, 0);
    else if (ch >= 193 && ch <= 288) m = span(193, KIND_FRONT, 0, THR_BAR, 8, 0, 0);
    else if (ch >= 289 && ch <= 384) m = span(289, KIND_FRONT, 1, THR_BAR, 8, 0, 0);
    else if (ch >= 385 && ch <= 400) m = span(385, KIND_BACK, 1, THR_BAR, 4, 0, 0);
    else if (ch >= 401 && ch <= 416) m = span(401, KIND_BACK, 1, THR_BAR, 4, 6, 0);
    else if (ch >= 417 && ch <= 424) m = span(417, KIND_BACK, 1, THR_BAR, 4, 4, 0);
    else if (ch >= 425 && ch <= 432) m = span(425, KIND_BACK, 1, THR_BAR, 4, 10, 0);
    else if (ch >= 433 && ch <= 496) m = span(433, KIND_TELE, 1, THR_TEL, 8, 0, 0);
    else if (ch >= 497 && ch <= 560) m = span(497, KIND_RING, 1, THR_RS, 32, 0, 0);
    else if (ch >= 561 && ch <= 564) m = span(561, KIND_SECTOR, 1, THR_RS, 4, 0, 0);
    else if (ch >= 569 && ch <= 572) m = span(569, KIND_SECTOR, 1, THR_RS, 4, 1, 0);
    else if (ch >= 577 && ch <= 640) m = span(577, KIND_RING, 1, THR_RS, 32, 2, 0);
    else if (ch >= 641 && ch <= 672) m = span(641, KIND_RING, 1, THR_RS, 32, 5, 0);
    else if (ch >= 673 && ch <= 676) m = span(673, KIND_SECTOR, 1, THR_RS, 4, 2, 0);
    else if (ch >= 677 && ch <= 680) m = span(677, KIND_SECTOR, 1, THR_RS, 4, 4, 1);
    else if (ch >= 681 && ch <= 684) m = span(681, KIND_SECTOR, 1, THR_RS, 4, 3, 0);
    else if (ch >= 685 && ch <= 688) m = span(685, KIND_SECTOR, 1, THR_RS, 4, 5, 0);
    return m;
  endfunction

  task automatic classify_word(input logic [31:0] raw);
    logic [31:0] word;
    logic [11:0] ch;
    logic [15:0] a;
    logic [15:0] limit;
    int unsigned off;
    chan_map_t m;
    hit_rec_t h;
    word = {raw[15:0], raw[31:16]};
    h.kind = KIND_END;
    h.ds = 1'b0;
    h.det = '0;
    h.strip = '0;
    h.left = 1'b0;
    h.ch = '0;
    h.adc = '0;
    h.stamp = '0;
    h.tdc_g = '0;
    h.tdc_r = '0;
    h.tdc_s = '0;
    h.last = 1'b1;
    if (word == END_MARK) begin
      h.stamp = stamp_bits;
      h.tdc_g = gamma_seen;
      h.tdc_r = rf_seen;
      h.tdc_s = silicon_seen;
      expected_hits.insert(expected_hits.size(), h);
      stamp_bits = '0;
      gamma_seen = '0;
      rf_seen = '0;
      silicon_seen = '0;
      return;
    end
    ch = word[27:16];
    a = word[15:0];
    if (ch >= CH_STAMP_LO && ch <= CH_STAMP_HI)
      stamp_bits = stamp_bits | (64'(a) << (16 * (ch - CH_STAMP_LO)));
    if (ch == CH_TDC_GAMMA) begin
      gamma_seen = a;
      return;
    end
    if (ch == CH_TDC_RF) begin
      rf_seen = a;
      return;
    end
    if (ch == CH_TDC_SILICON) begin
      silicon_seen = a;
      return;
    end
    m = map_channel(ch);
    if (!m.hit) return;
    limit = (m.thr == THR_RS) ? rs_limit : (m.thr == THR_BAR) ? barrel_limit : tele_limit;
    if (a <= limit) return;
    off = ch - m.lo;
    h.kind = m.kind;
    h.ds = m.ds;
    h.det = 4'(off / m.div) + m.base;
    h.strip = 5'(off % m.div);
    h.ch = ch;
    h.adc = a;
    if (m.kind == KIND_FRONT) begin
      h.strip = h.strip >> 1;
      h.left = ~ch[0];
    end
    if (m.dual) begin
      // sector beat first, then the ring beat closes the word
      h.last = 1'b0;
      expected_hits.insert(expected_hits.size(), h);
      h.kind = KIND_RING;
      h.last = 1'b1;
    end
    expected_hits.insert(expected_hits.size(), h);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // swapped word is {hi, ch, adc}; high bits are don't-care, so randomize them
  function automatic logic [31:0] pack_word(input logic [11:0] ch, input logic [15:0] a);
    logic [3:0] hi;
    hi = 4'($urandom_range(0, 15));
    return {a, hi, ch};
  endfunction

  function automatic logic [31:0] random_word();
    int unsigned pick;
    int unsigned sel;
    logic [11:0] ch;
    logic [15:0] a;
    logic [15:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 6) return END_MARK;
    if (pick < 14) return $urandom();
    if (pick < 24) begin
      sel = $urandom_range(0, 6);
      ch = (sel == 0) ? CH_TDC_GAMMA : (sel == 1) ? CH_TDC_RF :
           (sel == 2) ? CH_TDC_SILICON : CH_STAMP_LO + 12'(sel - 3);
    end else if (pick < 30) begin
      sel = $urandom_range(0, 3);
      ch = (sel == 0) ? 12'd0 : (sel == 1) ? 12'(565 + $urandom_range(0, 3)) :
           (sel == 2) ? 12'(573 + $urandom_range(0, 3)) : 12'($urandom_range(689, 4095));
    end else begin
      ch = 12'($urandom_range(1, 688));
    end
    if ($urandom_range(0, 3) == 0) begin
      sel = $urandom_range(0, 2);
      t = (sel == 0) ? rs_limit : (sel == 1) ? barrel_limit : tele_limit;
      a = t + 16'($urandom_range(0, 1));
    end else begin
      a = 16'($urandom());
    end
    return pack_word(ch, a);
  endfunction

  task automatic queue_word(input logic [31:0] raw);
    word_backlog.insert(word_backlog.size(), raw);
    words_queued++;
  endtask

  task automatic write_threshold(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RING_SECTOR: rs_limit = val;
      CFG_BARREL:      barrel_limit = val;
      CFG_TELESCOPE:   tele_limit = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [15:0] rs, input logic [15:0] bar,
                                input logic [15:0] tel);
    write_threshold(CFG_RING_SECTOR, rs);
    write_threshold(CFG_BARREL, bar);
    write_threshold(CFG_TELESCOPE, tel);
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) queue_word(random_word());
    wait_drained();
  endtask

  // input driver: one beat per backlog entry, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        classify_word(raw_word);
        words_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (word_backlog.size() > 0) begin
          raw_word <= word_backlog.pop_front();
          next_valid = 1'b1;
          in_gap = fast_in ? 0 : $urandom_range(0, 3);
          if ($urandom_range(0, 39) == 0) fast_in = ~fast_in;
        end
      end
      in_valid <= next_valid;
    end
  end

  // output monitor: check each beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result beat: kind %0d channel %0d", kind, channel);
          mismatches++;
        end else begin
          exp_hit = expected_hits.pop_front();
          check_field("kind", exp_hit.kind, kind);
          check_field("downstream", exp_hit.ds, downstream);
          check_field("detector", exp_hit.det, detector);
          check_field("strip", exp_hit.strip, strip);
          check_field("left_side", exp_hit.left, left_side);
          check_field("channel", exp_hit.ch, channel);
          check_field("adc", exp_hit.adc, adc);
          check_field("time_stamp", exp_hit.stamp, time_stamp);
          check_field("tdc_gamma", exp_hit.tdc_g, tdc_gamma);
          check_field("tdc_rf", exp_hit.tdc_r, tdc_rf);
          check_field("tdc_silicon", exp_hit.tdc_s, tdc_silicon);
          check_field("last", exp_hit.last, last);
        end
        beats_seen++;
        // hold off long enough to back the queue up into the input
        if (beats_seen == 120 || beats_seen == 450) out_stall = LONG_HOLD;
        else out_stall = fast_out ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) fast_out = ~fast_out;
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_detector_channel_hit_classifier_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed pass at reset thresholds
    queue_word(pack_word(12'd0, 16'hffff));
    queue_word(pack_word(12'd1, 16'h0000));
    queue_word(pack_word(12'd1, 16'h0001));
    queue_word(pack_word(12'd128, 16'hffff));
    queue_word(pack_word(12'd129, 16'h8000));
    queue_word(pack_word(12'd192, 16'h00ff));
    queue_word(pack_word(12'd193, 16'h1234));
    queue_word(pack_word(12'd194, 16'h4321));
    queue_word(pack_word(12'd384, 16'h7fff));
    queue_word(pack_word(12'd432, 16'h0100));
    queue_word(pack_word(12'd433, 16'h0002));
    queue_word(pack_word(12'd496, 16'hfffe));
    queue_word(pack_word(12'd565, 16'hffff));
    queue_word(pack_word(12'd677, 16'h00a5));
    queue_word(pack_word(12'd680, 16'h5a00));
    queue_word(pack_word(12'd688, 16'h0f0f));
    queue_word(pack_word(CH_TDC_GAMMA, 16'hbeef));
    queue_word(pack_word(CH_TDC_RF, 16'h0001));
    queue_word(pack_word(CH_TDC_SILICON, 16'hffff));
    queue_word(pack_word(CH_STAMP_LO, 16'hcafe));
    queue_word(pack_word(CH_STAMP_HI, 16'h8001));
    queue_word(32'hffff_efff);
    queue_word(END_MARK);
    queue_word(END_MARK);
    wait_drained();

    random_phase(300);
    set_thresholds(16'hffff, 16'hffff, 16'hffff);
    random_phase(250);
    set_thresholds(16'($urandom()), 16'($urandom()), 16'($urandom()));
    random_phase(300);
    set_thresholds(16'h0001, 16'h8000, 16'hfffe);
    random_phase(250);
    set_thresholds(16'($urandom()), 16'($urandom()), 16'($urandom()));
    random_phase(300);
    set_thresholds(16'h0000, 16'($urandom()), 16'hffff);
    random_phase(300);

    if (mismatches == 0 && expected_hits.size() == 0)
      $display("tb_detector_channel_hit_classifier_top OK");
    else
      $display("tb_detector_channel_hit_classifier_top NOT OK");
    $finish;
  end

endmodule

/* detector_channel_hit_classifier_top.f */
hdl/dchc_pkg.sv
hdl/dchc_front.sv
hdl/dchc_fifo.sv
hdl/dchc_back.sv
hdl/detector_channel_hit_classifier_top.sv
tb/tb_detector_channel_hit_classifier_top.sv
